// ===== rtl/core/u8enc_pkg.sv =====
// Package for the UTF-8 encoder: status codes, encoding constants and the byte encoder.
package u8enc_pkg;

    // Default width of the string byte counter
    localparam int unsigned COUNT_BITS_DEF = 16;

    localparam int unsigned CP_BITS    = 31;
    localparam int unsigned LIMIT_BITS = 16;
    localparam int unsigned TOTAL_BITS = 16;
    localparam int unsigned MAX_BYTES  = 6;

    // Lead byte marks and continuation byte form
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] LEAD5 = 8'hF8;
    localparam logic [7:0] LEAD6 = 8'hFC;
    localparam logic [7:0] CONT  = 8'h80;

    // Range bounds for each encoding length
    localparam logic [CP_BITS-1:0] BOUND2 = 31'h0000_0080;
    localparam logic [CP_BITS-1:0] BOUND3 = 31'h0000_0800;
    localparam logic [CP_BITS-1:0] BOUND4 = 31'h0001_0000;
    localparam logic [CP_BITS-1:0] BOUND5 = 31'h0020_0000;
    localparam logic [CP_BITS-1:0] BOUND6 = 31'h0400_0000;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_TERM     = 2'd1,
        ST_BUDGET   = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    // Encoded character: byte 0 goes out first
    typedef struct packed {
        logic [2:0]                 size;
        logic [MAX_BYTES-1:0][7:0]  bytes;
    } enc_t;

    // Continuation byte carrying six payload bits
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        cont_byte = CONT | {2'b00, bits};
    endfunction

    // Extended UTF-8 encoding of one code point, one to six bytes
    function automatic enc_t encode(input logic [CP_BITS-1:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp < BOUND2) begin
            e.size     = 3'd1;
            e.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < BOUND3) begin
            e.size     = 3'd2;
            e.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            e.bytes[1] = cont_byte(cp[5:0]);
        end else if (cp < BOUND4) begin
            e.size     = 3'd3;
            e.bytes[0] = LEAD3 | {4'h0, cp[15:12]};
            e.bytes[1] = cont_byte(cp[11:6]);
            e.bytes[2] = cont_byte(cp[5:0]);
        end else if (cp < BOUND5) begin
            e.size     = 3'd4;
            e.bytes[0] = LEAD4 | {5'h00, cp[20:18]};
            e.bytes[1] = cont_byte(cp[17:12]);
            e.bytes[2] = cont_byte(cp[11:6]);
            e.bytes[3] = cont_byte(cp[5:0]);
        end else if (cp < BOUND6) begin
            e.size     = 3'd5;
            e.bytes[0] = LEAD5 | {6'h00, cp[25:24]};
            e.bytes[1] = cont_byte(cp[23:18]);
            e.bytes[2] = cont_byte(cp[17:12]);
            e.bytes[3] = cont_byte(cp[11:6]);
            e.bytes[4] = cont_byte(cp[5:0]);
        end else begin
            e.size     = 3'd6;
            e.bytes[0] = LEAD6 | {7'h00, cp[30]};
            e.bytes[1] = cont_byte(cp[29:24]);
            e.bytes[2] = cont_byte(cp[23:18]);
            e.bytes[3] = cont_byte(cp[17:12]);
            e.bytes[4] = cont_byte(cp[11:6]);
            e.bytes[5] = cont_byte(cp[5:0]);
        end
        return e;
    endfunction

endpackage

// ===== rtl/core/utf8_encoder_with_byte_budget.sv =====
// UTF-8 encoder with a per-string byte budget: top level.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    code_point, first_of_string
//  out      source     out_valid / out_stall  data_byte, byte_present, last_of_item,
//                                             status, total_bytes
//  cfg      sink       cfg_we                 cfg_data (byte_limit)
//
// An item is encoded in the cycle it is accepted and loaded into the result buffer.
// Unless stalled, the buffer sends one result per cycle: one per byte of a character,
// one for a status-only result. The next item is accepted in the cycle the last result
// of the current one is taken, so unstalled ASCII text streams at one item per cycle.
// Reset clears the byte count, the ended flag, the budget and the buffer's valid flag.
// A stall on the output holds the buffer and stalls the input.
module utf8_encoder_with_byte_budget
    import u8enc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_we,
    input  logic [LIMIT_BITS-1:0]    cfg_data,
    // input items
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CP_BITS-1:0]       code_point,
    input  logic                     first_of_string,
    // result items
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               data_byte,
    output logic                     byte_present,
    output logic                     last_of_item,
    output logic [1:0]               status,
    output logic [TOTAL_BITS-1:0]    total_bytes
);

    localparam int unsigned EXT_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam int unsigned SUM_BITS = COUNT_BITS + 1;

    // Control state
    logic [LIMIT_BITS-1:0]      limit_reg;
    logic [COUNT_BITS-1:0]      bw_reg, bw_next;
    logic                       ended_reg, ended_next;
    logic                       valid_reg, valid_next;
    logic [2:0]                 left_reg, left_next;

    // Result buffer payload
    logic [MAX_BYTES-1:0][7:0]  bytes_reg, bytes_next;
    logic [COUNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                       present_reg, present_next;
    status_t                    stat_reg, stat_next;

    logic                       acc, take;
    logic [COUNT_BITS-1:0]      bw_eff, eff_limit;
    logic                       ended_eff;
    logic [EXT_BITS-1:0]        lim_ext, max_ext, cnt_ext;
    logic [SUM_BITS-1:0]        sum;
    logic                       fits;
    enc_t                       enc;

    // Handshakes: take new item when buffer empty or its last result leaves now
    assign take     = valid_reg & ~out_stall;
    assign in_stall = valid_reg & (out_stall | (left_reg != 3'd0));
    assign acc      = in_valid & ~in_stall;

    // Budget saturated to what the counter can hold
    assign max_ext   = EXT_BITS'({COUNT_BITS{1'b1}});
    assign lim_ext   = EXT_BITS'(limit_reg);
    assign eff_limit = (lim_ext > max_ext) ? COUNT_BITS'(max_ext) : COUNT_BITS'(lim_ext);

    // State seen by this item after a possible string restart
    assign bw_eff    = first_of_string ? '0 : bw_reg;
    assign ended_eff = first_of_string ? 1'b0 : ended_reg;

    // Encode and check the fit
    assign enc  = encode(code_point);
    assign sum  = SUM_BITS'(bw_eff) + SUM_BITS'(enc.size);
    assign fits = (sum <= SUM_BITS'(eff_limit));

    // Next state
    always_comb
    begin
        bw_next      = bw_reg;
        ended_next   = ended_reg;
        valid_next   = valid_reg;
        left_next    = left_reg;
        bytes_next   = bytes_reg;
        cnt_next     = cnt_reg;
        present_next = present_reg;
        stat_next    = stat_reg;

        // step through the buffer
        if (take)
        begin
            if (left_reg != 3'd0)
            begin
                bytes_next = bytes_reg >> 8;
                left_next  = left_reg - 3'd1;
                cnt_next   = cnt_reg + 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end

        // load a new item
        if (acc)
        begin
            valid_next   = 1'b1;
            left_next    = 3'd0;
            bytes_next   = '0;
            present_next = 1'b0;
            cnt_next     = bw_eff;
            bw_next      = bw_eff;
            ended_next   = ended_eff;
            if (ended_eff)
            begin
                stat_next = ST_IGNORED;
            end
            else if (code_point == '0)
            begin
                // terminator, sent as a zero byte if room remains
                stat_next    = ST_TERM;
                ended_next   = 1'b1;
                present_next = (bw_eff < eff_limit);
            end
            else if (!fits)
            begin
                stat_next  = ST_BUDGET;
                ended_next = 1'b1;
                bw_next    = eff_limit;
                cnt_next   = eff_limit;
            end
            else
            begin
                stat_next    = ST_PROGRESS;
                present_next = 1'b1;
                bytes_next   = enc.bytes;
                left_next    = enc.size - 3'd1;
                cnt_next     = bw_eff + 1'b1;
                bw_next      = sum[COUNT_BITS-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            bw_reg    <= '0;
            ended_reg <= 1'b0;
            valid_reg <= 1'b0;
            left_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            bw_reg    <= bw_next;
            ended_reg <= ended_next;
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bytes_reg   <= bytes_next;
        cnt_reg     <= cnt_next;
        present_reg <= present_next;
        stat_reg    <= stat_next;
    end

    // Outputs
    assign cnt_ext      = EXT_BITS'(cnt_reg);
    assign out_valid    = valid_reg;
    assign data_byte    = bytes_reg[0];
    assign byte_present = present_reg;
    assign last_of_item = (left_reg == 3'd0);
    assign status       = stat_reg;
    assign total_bytes  = cnt_ext[TOTAL_BITS-1:0];

endmodule

// ===== verif/testbench.sv =====
// Testbench for utf8_encoder_with_byte_budget: random and directed code points, byte-level checking.
`timescale 1ns / 100ps

module testbench;
    import u8enc_pkg::*;

    localparam int unsigned CNT_BITS  = COUNT_BITS_DEF;
    localparam int unsigned COUNT_MAX = (CNT_BITS >= 32) ? 32'hFFFF_FFFF
                                                         : (32'd1 << CNT_BITS) - 1;
    localparam int unsigned WATCHDOG  = 2000;
    localparam int unsigned LONG_HOLD = 60;

    // One character item as offered to the encoder
    typedef struct packed {
        logic [CP_BITS-1:0] cp;
        logic               first;
    } char_item_t;

    // One expected output byte or status result
    typedef struct {
        logic [7:0]            data;
        logic                  present;
        logic                  last;
        status_t               st;
        logic [TOTAL_BITS-1:0] total;
    } enc_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [LIMIT_BITS-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CP_BITS-1:0]    code_point = '0;
    logic                  first_of_string = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            data_byte;
    logic                  byte_present;
    logic                  last_of_item;
    logic [1:0]            status;
    logic [TOTAL_BITS-1:0] total_bytes;

    char_item_t  pending_chars[$];
    enc_result_t expected_stream[$];

    // Predictor state: budget copy, byte count and ended flag of the current string
    int unsigned budget = 0;
    int unsigned str_count = 0;
    bit          str_done = 1'b0;

    int unsigned mismatches = 0;
    int unsigned string_items = 0;
    bit          idle_on = 1'b1;
    bit          offering = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          long_hold_armed = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned quiet = 0;

    utf8_encoder_with_byte_budget #(
        .COUNT_BITS      (CNT_BITS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .code_point      (code_point),
        .first_of_string (first_of_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .data_byte       (data_byte),
        .byte_present    (byte_present),
        .last_of_item    (last_of_item),
        .status          (status),
        .total_bytes     (total_bytes)
    );

    always #10 clk = ~clk;

    // Encoded length of a code point
    function automatic int unsigned char_length(input logic [CP_BITS-1:0] cp);
        if (cp < BOUND2) return 1;
        if (cp < BOUND3) return 2;
        if (cp < BOUND4) return 3;
        if (cp < BOUND5) return 4;
        if (cp < BOUND6) return 5;
        return 6;
    endfunction

    function automatic void push_result(input logic [7:0] data, input logic present,
                                        input logic last, input status_t st);
        enc_result_t r;
        r.data    = data;
        r.present = present;
        r.last    = last;
        r.st      = st;
        r.total   = str_count[TOTAL_BITS-1:0];
        expected_stream.push_back(r);
    endfunction

    // Expected results of one accepted character item
    function automatic void predict_encoding(input logic [CP_BITS-1:0] cp,
                                             input logic first);
        int unsigned n;
        int unsigned lim;
        logic [31:0] chunk;
        logic [7:0]  mark;
        logic [7:0]  b;
        if (first)
        begin
            str_count = 0;
            str_done  = 1'b0;
        end
        lim = (budget < COUNT_MAX) ? budget : COUNT_MAX;
        if (str_done)
        begin
            push_result(8'h00, 1'b0, 1'b1, ST_IGNORED);
            return;
        end
        if (cp == '0)
        begin
            // terminator goes out only when a byte of room is left
            str_done = 1'b1;
            push_result(8'h00, str_count < lim, 1'b1, ST_TERM);
            return;
        end
        n = char_length(cp);
        if (str_count + n > lim)
        begin
            str_count = lim;
            str_done  = 1'b1;
            push_result(8'h00, 1'b0, 1'b1, ST_BUDGET);
            return;
        end
        case (n)
            2:       mark = LEAD2;
            3:       mark = LEAD3;
            4:       mark = LEAD4;
            5:       mark = LEAD5;
            6:       mark = LEAD6;
            default: mark = 8'h00;
        endcase
        for (int i = 0; i < n; i++)
        begin
            chunk = {1'b0, cp} >> (6 * (n - 1 - i));
            if (i == 0)
                b = mark | chunk[7:0];
            else
                b = CONT | {2'b00, chunk[5:0]};
            str_count = (str_count + 1) & COUNT_MAX;
            push_result(b, 1'b1, i == n - 1, ST_PROGRESS);
        end
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // Feeder: presents queued items, random gaps after some accepted ones when idle_on is set
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_encoding(code_point, first_of_string);
                void'(pending_chars.pop_front());
                offering = 1'b0;
                if (idle_on && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            if (!offering)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pending_chars.size() != 0)
                    offering = 1'b1;
            end
            in_valid <= offering;
            if (offering)
            begin
                code_point      <= pending_chars[0].cp;
                first_of_string <= pending_chars[0].first;
            end
        end
    end

    // Result checker and output stall generator
    always @(posedge clk)
    begin
        enc_result_t exp_r;
        bit          stall_next;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_stream.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got byte 0x%0h status %0d",
                             $time, data_byte, status);
                end
                else
                begin
                    exp_r = expected_stream.pop_front();
                    compare_field("data_byte", exp_r.data, data_byte);
                    compare_field("byte_present", exp_r.present, byte_present);
                    compare_field("last_of_item", exp_r.last, last_of_item);
                    compare_field("status", exp_r.st, status);
                    compare_field("total_bytes", exp_r.total, total_bytes);
                end
            end
            // one long hold-off lets the encoder back up into its input
            if (long_hold_armed && !long_hold_done)
            begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            out_stall <= stall_next;
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet == WATCHDOG)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void push_char(input logic [CP_BITS-1:0] cp, input logic first);
        char_item_t it;
        it.cp    = cp;
        it.first = first;
        pending_chars.push_back(it);
    endfunction

    function automatic logic [CP_BITS-1:0] random_char();
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: return CP_BITS'($urandom_range(1, BOUND2 - 1));
            5:       return CP_BITS'($urandom_range(BOUND2, BOUND3 - 1));
            6:       return CP_BITS'($urandom_range(BOUND3, BOUND4 - 1));
            7:       return CP_BITS'($urandom_range(BOUND4, BOUND5 - 1));
            8:       return CP_BITS'($urandom_range(BOUND5, BOUND6 - 1));
            9, 10:   return CP_BITS'($urandom_range(BOUND6, 32'h7FFF_FFFF));
            default: return CP_BITS'($urandom);   // any value, zero included
        endcase
    endfunction

    // One string: mostly clean start and terminator, some broken ones and trailing noise
    function automatic void queue_string();
        int unsigned len;
        len = $urandom_range(0, 10);
        push_char(($urandom_range(0, 15) == 0) ? '0 : random_char(), $urandom_range(0, 7) != 0);
        for (int k = 0; k < len; k++)
            push_char(random_char(), $urandom_range(0, 19) == 0);
        string_items += len + 1;
        if ($urandom_range(0, 3) != 0)
        begin
            push_char('0, 1'b0);
            string_items++;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            push_char(random_char(), 1'b0);
            string_items++;
        end
    endfunction

    task automatic wait_drained();
        while (pending_chars.size() != 0 || offering || expected_stream.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_budget(input logic [LIMIT_BITS-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        budget = 32'(value);
    endtask

    task automatic random_phase(input logic [LIMIT_BITS-1:0] lim, input bit idle,
                                input int unsigned target);
        wait_drained();
        idle_on = idle;
        write_budget(lim);
        string_items = 0;
        while (string_items < target)
            queue_string();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // budget still at its reset value of zero: no room at all
        push_char(31'h41, 1'b1);
        push_char('0, 1'b1);
        push_char(31'h42, 1'b0);

        // full budget: every encoding length at both ends of its range
        wait_drained();
        write_budget(16'hFFFF);
        push_char(31'h41, 1'b1);
        push_char(BOUND2 - 1'b1, 1'b0);
        push_char(BOUND2, 1'b0);
        push_char(BOUND3 - 1'b1, 1'b0);
        push_char(BOUND3, 1'b0);
        push_char(BOUND4 - 1'b1, 1'b0);
        push_char(BOUND4, 1'b0);
        push_char(BOUND5 - 1'b1, 1'b0);
        push_char(BOUND5, 1'b0);
        push_char(BOUND6 - 1'b1, 1'b0);
        push_char(BOUND6, 1'b0);
        push_char(31'h7FFF_FFFF, 1'b0);
        push_char('0, 1'b0);

        // tight budget: overflow, ignore after end, exact fill, terminator without room
        wait_drained();
        write_budget(16'd4);
        push_char(BOUND3, 1'b1);
        push_char(BOUND2, 1'b0);
        push_char(31'h41, 1'b0);
        push_char(31'h41, 1'b1);
        push_char(31'h7F, 1'b0);
        push_char(31'h41, 1'b0);
        push_char(31'h41, 1'b0);
        push_char('0, 1'b0);
        push_char(31'h7FFF_FFFF, 1'b1);

        // random strings over a range of budgets
        random_phase(16'd3, 1'b1, 45);
        random_phase(16'd1, 1'b1, 40);
        random_phase(16'd12, 1'b0, 45);
        random_phase(16'd40, 1'b1, 45);
        random_phase(LIMIT_BITS'($urandom_range(2, 300)), 1'b1, 45);
        random_phase(16'hFFFF, 1'b1, 45);
        long_hold_armed = 1'b1;
        random_phase(LIMIT_BITS'($urandom_range(0, 16'hFFFF)), 1'b0, 45);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
